// ===== rtl/block_mean_ascii_quantizer_assert.svh =====
// Assertion macros shared by the block mean ASCII quantizer RTL.
`ifndef BLOCK_MEAN_ASCII_QUANTIZER_ASSERT_SVH
`define BLOCK_MEAN_ASCII_QUANTIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BMAQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BMAQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bmaq_pkg.sv =====
// Shared types, constants and functions of the block mean ASCII quantizer.
`default_nettype none

package bmaq_pkg;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 13;
  localparam int ROW_W      = 12;
  localparam int CODE_W     = 7;
  localparam int WIDTH_W    = 10;
  localparam int HEIGHT_W   = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int IDX_W      = 4;

  localparam int RampLevels = 9;
  localparam int NumThr     = RampLevels - 1;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int BLOCK_ROWS_DEF = 6;
  localparam int BLOCK_COLS_DEF = 3;
  localparam int SUM_DEPTH_DEF  = (MAX_WIDTH_DEF + BLOCK_COLS_DEF - 1) / BLOCK_COLS_DEF;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 10'd400;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd220;
  localparam logic [CODE_W-1:0]   CHAR_NEWLINE = 7'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Smallest mean that selects ramp entry k: ceil(k * 256 / 9).
  function automatic int ramp_threshold(input int k);
    return (k * 256 + RampLevels - 1) / RampLevels;
  endfunction

  function automatic logic [CODE_W-1:0] ramp_char(input logic [IDX_W-1:0] idx);
    logic [CODE_W-1:0] code;
    case (idx)
      4'd0:    code = 7'h20;  // space
      4'd1:    code = 7'h2E;  // .
      4'd2:    code = 7'h3A;  // :
      4'd3:    code = 7'h2D;  // -
      4'd4:    code = 7'h3D;  // =
      4'd5:    code = 7'h2A;  // *
      4'd6:    code = 7'h23;  // #
      4'd7:    code = 7'h25;  // %
      default: code = 7'h40;  // @, also any index past the ramp
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/block_mean_ascii_quantizer.sv =====
// Top level of the block mean ASCII quantizer: counters, accumulate stage, output.
`default_nettype none
`include "block_mean_ascii_quantizer_assert.svh"

// Usage
//   s_axis carries one 8-bit grayscale pixel per beat in raster order.
//   m_axis carries one character per beat: tdata[6:0] is the glyph code or a
//   newline (10), tlast marks the final character caused by one pixel, and
//   tuser marks the newline that closes the image.
//   image_width (index 0) and image_height (index 1) are written through the
//   cfg port while the block is idle.
// Throughput
//   One pixel per cycle is sustained while the output does not stall; the
//   limit is the read-modify-write of the accumulator memory, one read and
//   one write port, with forwarding between back-to-back pixels of the same
//   block. A band-end pixel that yields a glyph and a newline holds the
//   output for two beats.
// Reset
//   Positions go to zero, width to 400, height to 220, the pipeline empties.
//   The accumulator memory is not cleared: the first row of each band writes
//   the sum of each block in that row before it is read.
// Stall
//   A stalled output holds its beat; a pixel with a result then waits in the
//   accumulate stage and s_axis_tready drops until the output frees.
module block_mean_ascii_quantizer #(
  parameter int MAX_WIDTH  = bmaq_pkg::MAX_WIDTH_DEF,
  parameter int BLOCK_ROWS = bmaq_pkg::BLOCK_ROWS_DEF,
  parameter int BLOCK_COLS = bmaq_pkg::BLOCK_COLS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // cfg write port
  input  wire logic                            cfg_we_i,
  input  wire logic [bmaq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bmaq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // pixel stream
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [7:0]                      s_axis_tdata_i,   // [7:0] pixel
  // character stream
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic      [7:0]                      m_axis_tdata_o,   // [6:0] char_code, [7] zero
  output logic                                 m_axis_tlast_o,
  output logic      [0:0]                      m_axis_tuser_o    // [0] frame_end
);
  import bmaq_pkg::*;

  localparam int SumDepth = (MAX_WIDTH + BLOCK_COLS - 1) / BLOCK_COLS;
  localparam int ColW     = $clog2(MAX_WIDTH);
  localparam int EffW     = ((ColW > WIDTH_W) ? ColW : WIDTH_W) + 1;
  localparam int BlkW     = (SumDepth > 1) ? $clog2(SumDepth) : 1;
  localparam int SubW     = (BLOCK_COLS > 1) ? $clog2(BLOCK_COLS) : 1;
  localparam int RibW     = (BLOCK_ROWS > 1) ? $clog2(BLOCK_ROWS) : 1;
  localparam int CntW     = $clog2(BLOCK_ROWS * BLOCK_COLS + 1);
  localparam int ThrW     = PIX_W + CntW;
  localparam int CmpW     = (ThrW > SUM_W) ? ThrW : SUM_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Position counters; block index and column within block run alongside the
  // column so no division by the block width is needed.
  // ---------------------------------------------------------------------------
  logic [ColW-1:0]  col_q, col_d;
  logic [SubW-1:0]  sub_q, sub_d;
  logic [BlkW-1:0]  blk_q, blk_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [RibW-1:0]  rib_q, rib_d;

  logic [EffW-1:0]  w_ext, w_sat, w_last;
  logic [ROW_W-1:0] h_last;
  logic             row_end, img_end, band_end, sub_last, block_end;
  logic             overwrite, emit;
  logic [CntW-1:0]  count;
  logic [ThrW-1:0]  thr [NumThr];

  logic accept, s1_adv;

  always_comb begin
    w_ext = EffW'(width_q);
    if (width_q == '0) begin
      w_sat = EffW'(1);
    end else if (w_ext > EffW'(MAX_WIDTH)) begin
      w_sat = EffW'(MAX_WIDTH);
    end else begin
      w_sat = w_ext;
    end
    w_last = w_sat - EffW'(1);
    h_last = (height_q == '0) ? '0 : height_q - ROW_W'(1);

    row_end   = EffW'(col_q) >= w_last;
    img_end   = row_q >= h_last;
    band_end  = img_end || (rib_q >= RibW'(BLOCK_ROWS - 1));
    sub_last  = sub_q == SubW'(BLOCK_COLS - 1);
    block_end = row_end || sub_last;
    overwrite = (rib_q == '0) && (sub_q == '0);
    emit      = band_end && block_end;
    count     = CntW'((RibW'(rib_q) + (RibW + 1)'(1)) * ((SubW + 1)'(sub_q) + (SubW + 1)'(1)));
  end

  // Mean >= T_k exactly when sum >= T_k * count; precompute the products.
  always_comb begin
    for (int k = 0; k < NumThr; k++) begin
      thr[k] = ThrW'(ThrW'(ramp_threshold(k + 1)) * ThrW'(count));
    end
  end

  always_comb begin
    col_d = col_q;
    sub_d = sub_q;
    blk_d = blk_q;
    row_d = row_q;
    rib_d = rib_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        sub_d = '0;
        blk_d = '0;
        if (img_end) begin
          row_d = '0;
          rib_d = '0;
        end else begin
          row_d = row_q + ROW_W'(1);
          rib_d = band_end ? '0 : rib_q + RibW'(1);
        end
      end else begin
        col_d = col_q + ColW'(1);
        if (sub_last) begin
          sub_d = '0;
          if (blk_q != BlkW'(SumDepth - 1)) begin
            blk_d = blk_q + BlkW'(1);
          end
        end else begin
          sub_d = sub_q + SubW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      sub_q <= '0;
      blk_q <= '0;
      row_q <= '0;
      rib_q <= '0;
    end else begin
      col_q <= col_d;
      sub_q <= sub_d;
      blk_q <= blk_d;
      row_q <= row_d;
      rib_q <= rib_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Accumulate stage: the memory registers the read data at accept
  // ---------------------------------------------------------------------------
  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [BlkW-1:0]  s1_blk_q;
  logic             s1_ovw_q, s1_emit_q, s1_row_end_q, s1_img_end_q;
  logic [ThrW-1:0]  s1_thr_q [NumThr];
  logic             fwd_hit_q, fwd_hit_d;
  logic [SUM_W-1:0] fwd_sum_q;
  logic [SUM_W-1:0] rd_data, operand, new_sum;
  logic [IDX_W-1:0] ramp_idx;

  logic             out_valid_q, out_phase_q, out_nl_q, out_fe_q;
  logic [CODE_W-1:0] out_code_q;
  logic             out_fire, out_done;

  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;
  assign out_done = out_fire && m_axis_tlast_o;

  // Advance when there is nothing to show, or the output is free this cycle.
  assign s1_adv = s1_valid_q && (!s1_emit_q || !out_valid_q || out_done);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  bmaq_sum_ram #(
    .DEPTH  (SumDepth),
    .ADDR_W (BlkW)
  ) u_sum_ram (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (blk_q),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_blk_q),
    .wr_data_i (new_sum)
  );

  // The read for a pixel that follows into the same block sees the old
  // entry; take the value being written instead.
  assign operand = fwd_hit_q ? fwd_sum_q : rd_data;
  assign new_sum = s1_ovw_q ? SUM_W'(s1_pix_q) : operand + SUM_W'(s1_pix_q);

  always_comb begin
    ramp_idx = '0;
    for (int k = 0; k < NumThr; k++) begin
      if (CmpW'(new_sum) >= CmpW'(s1_thr_q[k])) begin
        ramp_idx = ramp_idx + IDX_W'(1);
      end
    end
  end

  always_comb begin
    fwd_hit_d = fwd_hit_q;
    if (accept) begin
      fwd_hit_d = s1_valid_q && (s1_blk_q == blk_q);
    end else if (s1_adv) begin
      fwd_hit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      fwd_hit_q <= fwd_hit_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q     <= s_axis_tdata_i[PIX_W-1:0];
      s1_blk_q     <= blk_q;
      s1_ovw_q     <= overwrite;
      s1_emit_q    <= emit;
      s1_row_end_q <= row_end;
      s1_img_end_q <= img_end;
      s1_thr_q     <= thr;
      fwd_sum_q    <= new_sum;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: glyph beat, then an optional newline beat
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_phase_q <= 1'b0;
    end else if (s1_adv && s1_emit_q) begin
      out_valid_q <= 1'b1;
      out_phase_q <= 1'b0;
    end else if (out_fire) begin
      if (!out_phase_q && out_nl_q) begin
        out_phase_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b0;
        out_phase_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      out_code_q <= ramp_char(ramp_idx);
      out_nl_q   <= s1_row_end_q;
      out_fe_q   <= s1_img_end_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_phase_q ? CHAR_NEWLINE : out_code_q};
  assign m_axis_tlast_o  = out_phase_q || !out_nl_q;
  assign m_axis_tuser_o  = out_phase_q && out_fe_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BMAQ_ASSERT_IMPL(a_frame_end_on_newline, m_axis_tvalid_o && m_axis_tuser_o[0],
                    m_axis_tlast_o && (m_axis_tdata_o[CODE_W-1:0] == CHAR_NEWLINE),
                    "frame end flag on a beat that is not a final newline")
  `BMAQ_ASSERT_NEXT(a_emit_loads_output, s1_adv && s1_emit_q, m_axis_tvalid_o,
                    "pixel with a result left the accumulate stage without output")
  `BMAQ_ASSERT_IMPL(a_forward_needs_item, fwd_hit_q, s1_valid_q,
                    "forwarding flag set with the accumulate stage empty")
  `BMAQ_ASSERT_IMPL(a_newline_beat_valid, out_phase_q, out_valid_q && out_nl_q,
                    "newline beat pending without a held band-end result")

endmodule

`default_nettype wire

// ===== rtl/bmaq_sum_ram.sv =====
// Block accumulator memory: one write port, one read port, registered read data.
`default_nettype none

module bmaq_sum_ram #(
  parameter int DEPTH  = bmaq_pkg::SUM_DEPTH_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rd_en_i,
  input  wire logic [ADDR_W-1:0]          rd_addr_i,
  output logic      [bmaq_pkg::SUM_W-1:0] rd_data_o,
  input  wire logic                       wr_en_i,
  input  wire logic [ADDR_W-1:0]          wr_addr_i,
  input  wire logic [bmaq_pkg::SUM_W-1:0] wr_data_i
);
  import bmaq_pkg::*;

  logic [SUM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_block_mean_ascii_quantizer.sv =====
`timescale 1ns / 1ps
// Self-checking bench of block_mean_ascii_quantizer: directed table, full-width row, random phases.
module tb_block_mean_ascii_quantizer;
  import bmaq_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int STALL_PCT      = 37;    // chance in a hundred that a side idles in a cycle
  localparam int WATCHDOG_LIMIT = 1000;  // cycles without any beat before giving up
  localparam int SETTLE_CYCLES  = 4;     // lets the accumulate stage empty after the last char
  localparam int RANDOM_PIXELS  = 64;
  localparam int PHASE_MAX_PIX  = 60;    // longest random phase in pixels
  localparam int SUM_DEPTH      = SUM_DEPTH_DEF;

  // Glyph ramp, darkest to brightest.
  localparam logic [CODE_W-1:0] GLYPH [RampLevels] = '{
    7'h20, 7'h2E, 7'h3A, 7'h2D, 7'h3D, 7'h2A, 7'h23, 7'h25, 7'h40
  };
  localparam logic [CODE_W-1:0] GLYPH_SPACE = 7'h20;
  localparam logic [CODE_W-1:0] GLYPH_AT    = 7'h40;

  // One character beat as seen on m_axis.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
    logic              fend;
  } char_beat_t;

  // Directed table: a pixel beat or a register write. Where typed is set, the
  // row carries its own expectation: n_chars is 0 (nothing) or 2 (glyph, then
  // the newline with the given frame end flag).
  typedef enum logic [1:0] {
    ACT_PIXEL,
    ACT_WIDTH,
    ACT_HEIGHT
  } drive_e;

  typedef struct packed {
    drive_e            act;
    logic [11:0]       value;
    logic              typed;
    logic [1:0]        n_chars;
    logic [CODE_W-1:0] code;
    logic              fend;
  } intro_step_t;

  localparam int INTRO_LEN = 38;
  localparam intro_step_t INTRO_PLAN [INTRO_LEN] = '{
    // reset width 400: first pixel only opens a block
    '{ACT_PIXEL,  12'd255,  1'b1, 2'd0, GLYPH_SPACE, 1'b0},
    // zero width and zero height act as 1x1; the next pixel sits past the new row end
    '{ACT_WIDTH,  12'd0,    1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_HEIGHT, 12'd0,    1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd255,  1'b1, 2'd2, GLYPH_AT,    1'b1},
    '{ACT_PIXEL,  12'd0,    1'b1, 2'd2, GLYPH_SPACE, 1'b1},
    '{ACT_PIXEL,  12'd28,   1'b0, 2'd0, GLYPH_SPACE, 1'b0},  // last mean of the first level
    '{ACT_PIXEL,  12'd29,   1'b0, 2'd0, GLYPH_SPACE, 1'b0},  // first mean of the second level
    '{ACT_PIXEL,  12'd255,  1'b1, 2'd2, GLYPH_AT,    1'b1},
    // 2x2 image: one block cut short on both borders
    '{ACT_WIDTH,  12'd2,    1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_HEIGHT, 12'd2,    1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd255,  1'b1, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd255,  1'b1, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd255,  1'b1, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd255,  1'b1, 2'd2, GLYPH_AT,    1'b1},
    // 3x6 image, width shrunk to 1 after the first row: mean past the ramp clamps
    '{ACT_WIDTH,  12'd3,    1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_HEIGHT, 12'd6,    1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd255,  1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd255,  1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd255,  1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_WIDTH,  12'd1,    1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd200,  1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd200,  1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd200,  1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd200,  1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd200,  1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    // tallest image, then height cut mid-frame so the next row ends it
    '{ACT_WIDTH,  12'd2,    1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_HEIGHT, 12'd4095, 1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd60,   1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd190,  1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_HEIGHT, 12'd2,    1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd0,    1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd255,  1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    // width shrunk mid-row: column already past the new last column
    '{ACT_WIDTH,  12'd3,    1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd100,  1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd150,  1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_WIDTH,  12'd1,    1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd50,   1'b0, 2'd0, GLYPH_SPACE, 1'b0},
    '{ACT_PIXEL,  12'd250,  1'b0, 2'd0, GLYPH_SPACE, 1'b0}
  };

  // Clock, reset and DUT ports.
  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  cfg_we   = 1'b0;
  cfg_reg_e              cfg_idx  = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_valid  = 1'b0;
  logic [7:0]            s_data   = '0;
  logic                  m_ready  = 1'b0;
  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [7:0]            m_axis_tdata_o;   // [6:0] char_code, [7] zero
  logic                  m_axis_tlast_o;
  logic [0:0]            m_axis_tuser_o;   // [0] frame_end

  // Predictor state: block accumulators, raster position and registers.
  logic [SUM_W-1:0]    block_acc [SUM_DEPTH];
  logic [8:0]          col_pos  = '0;
  logic [ROW_W-1:0]    row_pos  = '0;
  logic [2:0]          band_row = '0;
  logic [WIDTH_W-1:0]  width_reg  = WIDTH_RESET;
  logic [HEIGHT_W-1:0] height_reg = HEIGHT_RESET;

  // Characters still owed by the DUT, oldest first.
  char_beat_t expected_chars [$];
  char_beat_t oldest;

  bit steady = 1'b0;  // set: neither side idles
  int mismatches    = 0;
  int quiet_cycles  = 0;
  int pixels_sent   = 0;
  int cfg_writes    = 0;
  int glyphs_seen   = 0;
  int newlines_seen = 0;
  int frames_seen   = 0;
  int clamped_means = 0;

  block_mean_ascii_quantizer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // Width register as the block sees it: zero acts as 1, large values saturate.
  function automatic int unsigned span_of_width(input logic [WIDTH_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return w;
  endfunction

  // Uniform intensities in two draws of five; the others pick an extreme or a
  // value around the lowest ramp threshold.
  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 4))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'($urandom_range(20, 40));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Fold one accepted pixel into the block sums and advance the raster
  // position. With enqueue set, on a block end in the band's last row queue
  // the glyph of the block mean; on a row end there, queue the newline too.
  task automatic quantize_pixel(input logic [7:0] pix, input bit enqueue);
    int unsigned w, h, blk, sub, cnt, mean, lvl;
    bit row_end, img_end, band_end, blk_end;
    char_beat_t glyph_beat, nl_beat;
    w   = span_of_width(width_reg);
    h   = (height_reg == 0) ? 1 : height_reg;
    blk = col_pos / BLOCK_COLS_DEF;
    if (blk >= SUM_DEPTH) blk = SUM_DEPTH - 1;
    sub = col_pos % BLOCK_COLS_DEF;

    // The first pixel of a block in the band's first row restarts its sum.
    if (band_row == 0 && sub == 0) block_acc[blk] = SUM_W'(pix);
    else block_acc[blk] = block_acc[blk] + SUM_W'(pix);

    row_end  = (col_pos >= w - 1);
    img_end  = (row_pos >= h - 1);
    band_end = img_end || (band_row >= BLOCK_ROWS_DEF - 1);
    blk_end  = row_end || (sub == BLOCK_COLS_DEF - 1);

    if (band_end && blk_end) begin
      // Divide by the pixels the block really holds, border cuts included.
      cnt  = (band_row + 1) * (sub + 1);
      mean = block_acc[blk] / cnt;
      lvl  = mean * RampLevels / 256;
      if (lvl > RampLevels - 1) begin
        lvl = RampLevels - 1;
        clamped_means++;
      end
      glyph_beat = '{code: GLYPH[lvl], last: !row_end, fend: 1'b0};
      nl_beat    = '{code: CHAR_NEWLINE, last: 1'b1, fend: img_end};
      if (enqueue) begin
        expected_chars.push_back(glyph_beat);
        if (row_end) expected_chars.push_back(nl_beat);
      end
    end

    if (row_end) begin
      col_pos = '0;
      if (img_end) begin
        row_pos  = '0;
        band_row = '0;
      end else begin
        row_pos  = row_pos + 1'b1;
        band_row = band_end ? 3'd0 : band_row + 3'd1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  // Offer one pixel beat, after a random gap unless steady, and return at
  // the edge that accepts it. Valid stays high for a back-to-back beat.
  task automatic send_pixel(input logic [7:0] value);
    if (!steady) begin
      while ($urandom_range(0, 99) < STALL_PCT) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_data  <= value;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pixels_sent++;
  endtask

  // Drop valid, drain every owed character, then give the last pixel without
  // a result time to leave the pipeline.
  task automatic wait_idle();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Pulse one register write; the extra edge keeps back-to-back writes from
  // dropping and raising the enable in one step.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) width_reg = value[WIDTH_W-1:0];
    else height_reg = value[HEIGHT_W-1:0];
    cfg_writes++;
    @(posedge clk_i);
  endtask

  // Receiver: stall at random, never inside a steady stretch.
  always @(posedge clk_i) begin
    m_ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
  end

  // Check every accepted character against the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("char beat with nothing owed, char_code", m_axis_tdata_o, -1);
      end else begin
        oldest = expected_chars.pop_front();
        if (m_axis_tdata_o !== {1'b0, oldest.code})
          report_mismatch("char_code", m_axis_tdata_o, oldest.code);
        if (m_axis_tlast_o !== oldest.last)
          report_mismatch("last", m_axis_tlast_o, oldest.last);
        if (m_axis_tuser_o[0] !== oldest.fend)
          report_mismatch("frame_end", m_axis_tuser_o[0], oldest.fend);
        if (oldest.code == CHAR_NEWLINE) begin
          newlines_seen++;
          if (oldest.fend) frames_seen++;
        end else begin
          glyphs_seen++;
        end
      end
    end
  end

  // Watchdog: count edges with no beat on either side.
  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d chars still owed",
               quiet_cycles, expected_chars.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    intro_step_t          step;
    logic [7:0]           pix;
    logic [WIDTH_W-1:0]   new_w;
    logic [HEIGHT_W-1:0]  new_h;
    logic [1:0]           junk;
    int unsigned          frame, count;
    int                   random_pixels, phase, intro_pixels;

    random_pixels = 0;
    phase         = 0;

    // Hold reset, then release it for good.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (int i = 0; i < INTRO_LEN; i++) begin
      step = INTRO_PLAN[i];
      case (step.act)
        ACT_WIDTH: begin
          wait_idle();
          write_reg(CFG_IMAGE_WIDTH, step.value);
        end
        ACT_HEIGHT: begin
          wait_idle();
          write_reg(CFG_IMAGE_HEIGHT, step.value);
        end
        default: begin
          send_pixel(step.value[7:0]);
          quantize_pixel(step.value[7:0], !step.typed);
          if (step.typed && step.n_chars != 0) begin
            expected_chars.push_back('{code: step.code, last: 1'b0, fend: 1'b0});
            expected_chars.push_back('{code: CHAR_NEWLINE, last: 1'b1, fend: step.fend});
          end
        end
      endcase
    end
    intro_pixels = pixels_sent;

    // One full-width row with the width register past the maximum: every
    // accumulator is used, and neither side idles for the whole stretch.
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 12'h3FF);
    write_reg(CFG_IMAGE_HEIGHT, 12'd1);
    steady = 1'b1;
    repeat (MAX_WIDTH_DEF) begin
      pix = pick_pixel();
      send_pixel(pix);
      quantize_pixel(pix, 1'b1);
    end
    steady = 1'b0;

    // Random phases: small images with random content, often cut off
    // mid-frame by the next register write.
    while (random_pixels < RANDOM_PIXELS) begin
      wait_idle();

      case ($urandom_range(0, 9))
        0:       new_w = '0;
        1:       new_w = WIDTH_W'($urandom_range(25, 1023));
        default: new_w = WIDTH_W'($urandom_range(1, 24));
      endcase
      // Grow the width only at the first row of a band: a wider row in a
      // later row would read a sum this band never wrote.
      if (band_row != 0 && span_of_width(new_w) > span_of_width(width_reg))
        new_w = width_reg;
      junk = 2'($urandom_range(0, 3));  // upper data bits are outside the register
      write_reg(CFG_IMAGE_WIDTH, {junk, new_w});

      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       new_h = '0;
          1:       new_h = HEIGHT_W'($urandom_range(15, 4095));
          default: new_h = HEIGHT_W'($urandom_range(1, 14));
        endcase
        write_reg(CFG_IMAGE_HEIGHT, new_h);
      end

      frame = span_of_width(width_reg) * ((height_reg == 0) ? 1 : height_reg);
      if (frame <= 150) begin
        count = frame * $urandom_range(1, 3);
        if ($urandom_range(0, 9) < 3) count += $urandom_range(1, frame);
      end else begin
        count = $urandom_range(20, 150);
      end
      if (count > PHASE_MAX_PIX) count = PHASE_MAX_PIX;

      for (int unsigned k = 0; k < count; k++) begin
        // Now and then hold the sender until every owed char is out.
        if (k == count / 2 && phase % 5 == 2) wait_idle();
        pix = pick_pixel();
        send_pixel(pix);
        quantize_pixel(pix, 1'b1);
        random_pixels++;
      end
      phase++;
    end

    // Drain and let the pipeline settle; the watchdog bounds the wait.
    wait_idle();

    $display("Covered %0d pixels (%0d directed, one full-width row) over %0d register writes.",
             pixels_sent, intro_pixels, cfg_writes);
    $display("Checked %0d glyphs, %0d newlines, %0d image ends, %0d clamped means.",
             glyphs_seen, newlines_seen, frames_seen, clamped_means);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
